[hw/rtl/qpcp_pkg.sv]
// qpcp_pkg: shared types and constants of the quaternion pinhole camera projection
// item payload structs, register indexes, fixed divider sizes and parameter defaults
// no dependencies
package qpcp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int QUAT_FRAC_BITS_DEF  = 30;

    // apb byte address: register i at 8*i, seven registers
    localparam int ADDR_W = 6;

    // projection quotient is clamped at 2^33, so 34 quotient bits are enough
    localparam int QUOT_BITS      = 34;
    localparam int PROJ_CLAMP_BIT = 33;

    // cycles the rotation matrix needs after a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_QUAT_W_X       = 3'd0;
    localparam t_reg_idx REG_QUAT_Y_Z       = 3'd1;
    localparam t_reg_idx REG_PRINCIPAL_SAMP = 3'd2;
    localparam t_reg_idx REG_PRINCIPAL_LINE = 3'd3;
    localparam t_reg_idx REG_FOCAL_LEN      = 3'd4;
    localparam t_reg_idx REG_SAMP_PITCH     = 3'd5;
    localparam t_reg_idx REG_LINE_PITCH     = 3'd6;

    typedef struct packed {
        logic              mode;
        logic signed [31:0] in_a;
        logic signed [31:0] in_b;
        logic signed [31:0] in_c;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic               divide_fault;
    } t_out;

endpackage

[hw/rtl/quaternion_pinhole_camera_projection.sv]
// quaternion_pinhole_camera_projection: QUOT_BITS + 7 register stages (41 by default); one item
// per cycle sustained while no result waits at the output and no register write is settling, the
// depth set mostly by the 34-stage restoring divider (one quotient bit each)
// the whole pipeline holds while a result waits at the output
// synchronous active-low reset clears valid bits and loads register defaults; no item
// is taken until the settle counter has run down after reset or after any register write (matrix rebuild)
// depends on qpcp_pkg
module quaternion_pinhole_camera_projection #(
    parameter int COORD_FRAC_BITS = qpcp_pkg::COORD_FRAC_BITS_DEF,
    parameter int QUAT_FRAC_BITS  = qpcp_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qpcp_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  qpcp_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output qpcp_pkg::t_out                o_out_data
);

    localparam int QF    = QUAT_FRAC_BITS;
    localparam int CF    = COORD_FRAC_BITS;
    localparam int QB    = qpcp_pkg::QUOT_BITS;
    localparam int QP_W  = 64 - QF;      // quaternion product
    localparam int QS_W  = 66 - QF;      // matrix element before saturation
    localparam int TW    = 66 - QF;      // one rotation term
    localparam int R_W   = 68 - QF;      // rotated component
    localparam int MAG_W = R_W - 1;
    localparam int DW    = MAG_W + 32;   // divisor
    localparam int NW    = DW + CF;      // dividend
    localparam int NSTG  = QB + 7;
    localparam logic [QB-1:0] CLAMP = QB'(1) << qpcp_pkg::PROJ_CLAMP_BIT;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] d;
        logic [QB-1:0] q;
        logic [QB-1:0] nlo;
        logic          dz;
        logic          ovf;
        logic          qneg;
        logic          nneg;
    } t_lane;

    typedef struct packed {
        logic           mode;
        qpcp_pkg::t_out res;
        t_lane          ls;
        t_lane          ll;
    } t_dstg;

    // ---------------------------------------------------------------- functions
    function automatic logic signed [QP_W-1:0] qmul(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [63:0] s;
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        p  = {32'b0, ma} * {32'b0, mb};
        s  = p >> QF;
        return (a[31] ^ b[31]) ? -QP_W'(s) : QP_W'(s);
    endfunction

    function automatic logic signed [TW-1:0] tmul(input logic signed [31:0] c,
                                                  input logic signed [32:0] v);
        logic [31:0] mc;
        logic [32:0] mv;
        logic [64:0] p;
        logic [64:0] s;
        mc = c[31] ? 32'(-c) : 32'(c);
        mv = v[32] ? 33'(-v) : 33'(v);
        p  = {33'b0, mc} * {32'b0, mv};
        s  = p >> QF;
        return (c[31] ^ v[32]) ? -TW'(s) : TW'(s);
    endfunction

    // saturation helpers return {flag, value}
    function automatic logic [32:0] sat_q(input logic signed [QS_W-1:0] v);
        logic ov;
        ov = !((&v[QS_W-1:31]) || !(|v[QS_W-1:31]));
        if (ov) begin
            return {1'b1, (v[QS_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] sat_r(input logic signed [R_W-1:0] v);
        logic ov;
        ov = !((&v[R_W-1:31]) || !(|v[R_W-1:31]));
        if (ov) begin
            return {1'b1, (v[R_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] sat_s(input logic signed [QB+1:0] v);
        logic ov;
        ov = !((&v[QB+1:31]) || !(|v[QB+1:31]));
        if (ov) begin
            return {1'b1, (v[QB+1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [32:0] sat_pre(input logic [64:0] m, input logic neg);
        logic [32:0] v;
        if (!neg && m > 65'h0_7FFF_FFFF) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (neg && m > 65'h0_8000_0000) begin
            return {1'b1, 32'h8000_0000};
        end
        v = neg ? -m[32:0] : m[32:0];
        return {1'b0, v[31:0]};
    endfunction

    // ---------------------------------------------------------------- registers
    logic [63:0]        r_quat_wx, r_quat_yz;
    logic signed [31:0] r_pr_samp, r_pr_line;
    logic [31:0]        r_focal, r_spr, r_lpr;
    logic [1:0]         r_settle;

    logic                    w_wr;
    qpcp_pkg::t_reg_idx      w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[qpcp_pkg::ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_wx <= 64'(1) << (QF + 32);
            r_quat_yz <= '0;
            r_pr_samp <= '0;
            r_pr_line <= '0;
            r_focal   <= 32'(1) << CF;
            r_spr     <= 32'(1) << CF;
            r_lpr     <= 32'(1) << CF;
            r_settle  <= qpcp_pkg::SETTLE_CYCLES;
        end else begin
            if (w_wr) begin
                r_settle <= qpcp_pkg::SETTLE_CYCLES;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            if (w_wr) begin
                unique case (w_idx)
                    qpcp_pkg::REG_QUAT_W_X:       r_quat_wx <= pwdata;
                    qpcp_pkg::REG_QUAT_Y_Z:       r_quat_yz <= pwdata;
                    qpcp_pkg::REG_PRINCIPAL_SAMP: r_pr_samp <= pwdata[31:0];
                    qpcp_pkg::REG_PRINCIPAL_LINE: r_pr_line <= pwdata[31:0];
                    qpcp_pkg::REG_FOCAL_LEN:      r_focal   <= pwdata[31:0];
                    qpcp_pkg::REG_SAMP_PITCH:     r_spr     <= pwdata[31:0];
                    qpcp_pkg::REG_LINE_PITCH:     r_lpr     <= pwdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            qpcp_pkg::REG_QUAT_W_X:       prdata = r_quat_wx;
            qpcp_pkg::REG_QUAT_Y_Z:       prdata = r_quat_yz;
            qpcp_pkg::REG_PRINCIPAL_SAMP: prdata = {32'b0, r_pr_samp};
            qpcp_pkg::REG_PRINCIPAL_LINE: prdata = {32'b0, r_pr_line};
            qpcp_pkg::REG_FOCAL_LEN:      prdata = {32'b0, r_focal};
            qpcp_pkg::REG_SAMP_PITCH:     prdata = {32'b0, r_spr};
            qpcp_pkg::REG_LINE_PITCH:     prdata = {32'b0, r_lpr};
            default:                      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- rotation matrix
    logic signed [QP_W-1:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_wy, r_wz, r_xy, r_xz, r_yz;
    logic signed [31:0]     r_mat [3][3];
    logic signed [31:0]     w_qw, w_qx, w_qy, w_qz;
    logic signed [QS_W-1:0] n_me [3][3];

    assign w_qw = r_quat_wx[63:32];
    assign w_qx = r_quat_wx[31:0];
    assign w_qy = r_quat_yz[63:32];
    assign w_qz = r_quat_yz[31:0];

    always_ff @(posedge i_clk) begin
        r_ww <= qmul(w_qw, w_qw);
        r_xx <= qmul(w_qx, w_qx);
        r_yy <= qmul(w_qy, w_qy);
        r_zz <= qmul(w_qz, w_qz);
        r_wx <= qmul(w_qw, w_qx);
        r_wy <= qmul(w_qw, w_qy);
        r_wz <= qmul(w_qw, w_qz);
        r_xy <= qmul(w_qx, w_qy);
        r_xz <= qmul(w_qx, w_qz);
        r_yz <= qmul(w_qy, w_qz);
    end

    always_comb begin
        n_me[0][0] = QS_W'(r_ww) + QS_W'(r_xx) - QS_W'(r_yy) - QS_W'(r_zz);
        n_me[0][1] = (QS_W'(r_xy) - QS_W'(r_wz)) <<< 1;
        n_me[0][2] = (QS_W'(r_xz) + QS_W'(r_wy)) <<< 1;
        n_me[1][0] = (QS_W'(r_xy) + QS_W'(r_wz)) <<< 1;
        n_me[1][1] = QS_W'(r_ww) - QS_W'(r_xx) + QS_W'(r_yy) - QS_W'(r_zz);
        n_me[1][2] = (QS_W'(r_yz) - QS_W'(r_wx)) <<< 1;
        n_me[2][0] = (QS_W'(r_xz) - QS_W'(r_wy)) <<< 1;
        n_me[2][1] = (QS_W'(r_yz) + QS_W'(r_wx)) <<< 1;
        n_me[2][2] = QS_W'(r_ww) - QS_W'(r_xx) - QS_W'(r_yy) + QS_W'(r_zz);
    end

    // a non-unit quaternion saturates elements without a fault
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_mat[i][j] <= 32'(sat_q(n_me[i][j]));
            end
        end
    end

    // ---------------------------------------------------------------- pipeline control
    logic [NSTG-1:0] r_vld;
    logic            w_adv;
    logic            w_acc;

    assign w_adv      = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = w_adv && (r_settle == 2'd0);
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], w_acc};
        end
    end

    // ---------------------------------------------------------------- stage 1: offset scale
    qpcp_pkg::t_in      r1_in;
    logic [64:0]        r1_pa, r1_pb, n1_pa, n1_pb;
    logic               r1_pan, r1_pbn;
    logic signed [32:0] w1_ea, w1_eb, w1_pa, w1_pb, w1_da, w1_db;
    logic [32:0]        w1_ma, w1_mb;

    always_comb begin
        w1_ea = {i_in_data.in_a[31], i_in_data.in_a};
        w1_eb = {i_in_data.in_b[31], i_in_data.in_b};
        w1_pa = {r_pr_samp[31], r_pr_samp};
        w1_pb = {r_pr_line[31], r_pr_line};
        w1_da = w1_ea - w1_pa;
        w1_db = w1_eb - w1_pb;
        w1_ma = w1_da[32] ? 33'(-w1_da) : 33'(w1_da);
        w1_mb = w1_db[32] ? 33'(-w1_db) : 33'(w1_db);
        n1_pa = {32'b0, w1_ma} * {33'b0, r_spr};
        n1_pb = {32'b0, w1_mb} * {33'b0, r_lpr};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_in  <= i_in_data;
            r1_pa  <= n1_pa;
            r1_pb  <= n1_pb;
            r1_pan <= w1_da[32];
            r1_pbn <= w1_db[32];
        end
    end

    // ---------------------------------------------------------------- stage 2: camera vector
    logic               r2_mode, r2_flag, n2_flag;
    logic signed [32:0] r2_v [3];
    logic signed [32:0] n2_v [3];
    logic [32:0]        w2_sa, w2_sb;

    always_comb begin
        w2_sa = sat_pre(r1_pa >> CF, r1_pan);
        w2_sb = sat_pre(r1_pb >> CF, r1_pbn);
        if (r1_in.mode) begin
            n2_v[0] = {w2_sa[31], w2_sa[31:0]};
            n2_v[1] = {w2_sb[31], w2_sb[31:0]};
            n2_v[2] = {1'b0, r_focal};
            n2_flag = w2_sa[32] || w2_sb[32];
        end else begin
            n2_v[0] = {r1_in.in_a[31], r1_in.in_a};
            n2_v[1] = {r1_in.in_b[31], r1_in.in_b};
            n2_v[2] = {r1_in.in_c[31], r1_in.in_c};
            n2_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_mode <= r1_in.mode;
            r2_flag <= n2_flag;
            for (int j = 0; j < 3; j++) begin
                r2_v[j] <= n2_v[j];
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: terms
    // projection uses the transposed matrix, back-projection the matrix itself
    logic                 r3_mode, r3_flag;
    logic signed [TW-1:0] r3_t [3][3];
    logic signed [TW-1:0] n3_t [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n3_t[i][j] = tmul(r2_mode ? r_mat[i][j] : r_mat[j][i], r2_v[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_mode <= r2_mode;
            r3_flag <= r2_flag;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_t[i][j] <= n3_t[i][j];
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 4: sums
    logic                  r4_mode, r4_flag;
    logic signed [R_W-1:0] r4_r [3];
    logic signed [R_W-1:0] n4_r [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_r[i] = R_W'(r3_t[i][0]) + R_W'(r3_t[i][1]) + R_W'(r3_t[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_mode <= r3_mode;
            r4_flag <= r3_flag;
            for (int i = 0; i < 3; i++) begin
                r4_r[i] <= n4_r[i];
            end
        end
    end

    // ---------------------------------------------------------------- stage 5: divider operands
    logic              r5_mode;
    qpcp_pkg::t_out    r5_res, n5_res;
    logic [NW-1:0]     r5_ns, r5_nl;
    logic [DW-1:0]     r5_ds, r5_dl, w5_ps, w5_pl;
    logic              r5_nneg_s, r5_nneg_l, r5_qneg_s, r5_qneg_l;
    logic [MAG_W-1:0]  w5_m [3];
    logic [32:0]       w5_sat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w5_m[i]   = r4_r[i][R_W-1] ? MAG_W'(-r4_r[i]) : MAG_W'(r4_r[i]);
            w5_sat[i] = sat_r(r4_r[i]);
        end
        w5_ps = {32'b0, w5_m[0]} * {{MAG_W{1'b0}}, r_focal};
        w5_pl = {32'b0, w5_m[1]} * {{MAG_W{1'b0}}, r_focal};
        if (r4_mode) begin
            n5_res.out_a        = w5_sat[0][31:0];
            n5_res.out_b        = w5_sat[1][31:0];
            n5_res.out_c        = w5_sat[2][31:0];
            n5_res.divide_fault = r4_flag || w5_sat[0][32] || w5_sat[1][32] || w5_sat[2][32];
        end else begin
            n5_res              = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_mode   <= r4_mode;
            r5_res    <= n5_res;
            r5_ns     <= {w5_ps, {CF{1'b0}}};
            r5_nl     <= {w5_pl, {CF{1'b0}}};
            r5_ds     <= {32'b0, w5_m[2]} * {{MAG_W{1'b0}}, r_spr};
            r5_dl     <= {32'b0, w5_m[2]} * {{MAG_W{1'b0}}, r_lpr};
            r5_nneg_s <= r4_r[0][R_W-1];
            r5_nneg_l <= r4_r[1][R_W-1];
            r5_qneg_s <= r4_r[0][R_W-1] ^ r4_r[2][R_W-1];
            r5_qneg_l <= r4_r[1][R_W-1] ^ r4_r[2][R_W-1];
        end
    end

    // ---------------------------------------------------------------- stage 6: range check
    // a quotient of 2^34 or more is caught here; the steps then give the low 34 bits
    t_dstg         r_dv [QB+1];
    t_dstg         n6_dv;
    logic [DW-1:0] w6_hs, w6_hl;

    always_comb begin
        w6_hs = DW'(r5_ns >> QB);
        w6_hl = DW'(r5_nl >> QB);
        n6_dv.mode    = r5_mode;
        n6_dv.res     = r5_res;
        n6_dv.ls.rem  = w6_hs;
        n6_dv.ls.d    = r5_ds;
        n6_dv.ls.q    = '0;
        n6_dv.ls.nlo  = r5_ns[QB-1:0];
        n6_dv.ls.dz   = (r5_ds == '0);
        n6_dv.ls.ovf  = (w6_hs >= r5_ds);
        n6_dv.ls.qneg = r5_qneg_s;
        n6_dv.ls.nneg = r5_nneg_s;
        n6_dv.ll.rem  = w6_hl;
        n6_dv.ll.d    = r5_dl;
        n6_dv.ll.q    = '0;
        n6_dv.ll.nlo  = r5_nl[QB-1:0];
        n6_dv.ll.dz   = (r5_dl == '0);
        n6_dv.ll.ovf  = (w6_hl >= r5_dl);
        n6_dv.ll.qneg = r5_qneg_l;
        n6_dv.ll.nneg = r5_nneg_l;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0] <= n6_dv;
        end
    end

    // ---------------------------------------------------------------- divider steps
    for (genvar k = 0; k < QB; k++) begin : g_div
        t_dstg       n_dv;
        logic [DW:0] w_ts, w_tl;
        logic        w_gs, w_gl;

        always_comb begin
            n_dv = r_dv[k];
            w_ts = {r_dv[k].ls.rem, r_dv[k].ls.nlo[QB-1-k]};
            w_tl = {r_dv[k].ll.rem, r_dv[k].ll.nlo[QB-1-k]};
            w_gs = (w_ts >= {1'b0, r_dv[k].ls.d});
            w_gl = (w_tl >= {1'b0, r_dv[k].ll.d});
            n_dv.ls.rem = w_gs ? DW'(w_ts - {1'b0, r_dv[k].ls.d}) : DW'(w_ts);
            n_dv.ll.rem = w_gl ? DW'(w_tl - {1'b0, r_dv[k].ll.d}) : DW'(w_tl);
            n_dv.ls.q   = {r_dv[k].ls.q[QB-2:0], w_gs};
            n_dv.ll.q   = {r_dv[k].ll.q[QB-2:0], w_gl};
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k+1] <= n_dv;
            end
        end
    end

    // ---------------------------------------------------------------- final: clamp and offset
    qpcp_pkg::t_out      r_out, n_out;
    logic [QB-1:0]       w_qs, w_ql;
    logic                w_negs, w_negl;
    logic signed [QB+1:0] w_vs, w_vl, w_ss, w_sl;
    logic [32:0]         w_fs, w_fl;

    always_comb begin
        w_qs   = (r_dv[QB].ls.dz || r_dv[QB].ls.ovf || r_dv[QB].ls.q > CLAMP) ?
                 CLAMP : r_dv[QB].ls.q;
        w_ql   = (r_dv[QB].ll.dz || r_dv[QB].ll.ovf || r_dv[QB].ll.q > CLAMP) ?
                 CLAMP : r_dv[QB].ll.q;
        // a zero divisor takes the sign of the numerator alone
        w_negs = r_dv[QB].ls.dz ? r_dv[QB].ls.nneg : r_dv[QB].ls.qneg;
        w_negl = r_dv[QB].ll.dz ? r_dv[QB].ll.nneg : r_dv[QB].ll.qneg;
        w_vs   = w_negs ? -{2'b0, w_qs} : {2'b0, w_qs};
        w_vl   = w_negl ? -{2'b0, w_ql} : {2'b0, w_ql};
        w_ss   = {{(QB-30){r_pr_samp[31]}}, r_pr_samp} + w_vs;
        w_sl   = {{(QB-30){r_pr_line[31]}}, r_pr_line} + w_vl;
        w_fs   = sat_s(w_ss);
        w_fl   = sat_s(w_sl);
        if (r_dv[QB].mode) begin
            n_out = r_dv[QB].res;
        end else begin
            n_out.out_a        = w_fs[31:0];
            n_out.out_b        = w_fl[31:0];
            n_out.out_c        = '0;
            n_out.divide_fault = r_dv[QB].ls.dz || r_dv[QB].ll.dz || w_fs[32] || w_fl[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule
